// ===== sv/llh_pkg.sv =====
// Shared types, codes and constants of the launch latency histogram.
package llh_pkg;

   localparam int NUM_BINS  = 10;
   localparam int BIN_W     = 4;
   localparam int TS_W      = 64;
   localparam int CNT_W     = 64;
   localparam int CMD_W     = 2;

   localparam logic [CMD_W-1:0] CMD_ENQUEUE = 2'd0;
   localparam logic [CMD_W-1:0] CMD_SAMPLE  = 2'd1;

   typedef enum logic [2:0] {
      ST_ENQUEUED   = 3'd0,
      ST_DROPPED    = 3'd1,
      ST_SAMPLED    = 3'd2,
      ST_EMPTY      = 3'd3,
      ST_ZERO_STAMP = 3'd4,
      ST_NOT_LEADER = 3'd5,
      ST_BIN_READ   = 3'd6
   } status_type;

   typedef enum logic [2:0] {
      S_IDLE   = 3'b001,
      S_EXEC   = 3'b010,
      S_UPDATE = 3'b100
   } state_type;

   // Command strobes from the controller to the datapath.
   typedef struct packed {
      logic accept;
      logic execute;
      logic update;
   } llh_cmd_type;

   localparam logic [TS_W-1:0] DECADE_LIMIT [NUM_BINS-1] = '{
      64'd100, 64'd1000, 64'd10000, 64'd100000, 64'd1000000,
      64'd10000000, 64'd100000000, 64'd1000000000, 64'd10000000000
   };

   // Smallest bin whose upper limit exceeds ns; last bin catches the rest.
   function automatic logic [BIN_W-1:0] decade_bin(input logic [TS_W-1:0] ns);
      logic [BIN_W-1:0] b;
      b = BIN_W'(NUM_BINS - 1);
      for (int i = NUM_BINS - 2; i >= 0; i--) begin
         if (ns < DECADE_LIMIT[i]) b = BIN_W'(i);
      end
      return b;
   endfunction

endpackage

// ===== sv/llh_ctrl.sv =====
// Controller state machine: sequences accept, execute and histogram update.
module llh_ctrl
   import llh_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output llh_cmd_type cmd
);

   state_type state_ff, state_in;
   logic      rsp_valid_ff, rsp_valid_in;
   logic      out_free;

   always_comb begin
      out_free    = !rsp_valid_ff || rsp_tready;
      cmd.update  = (state_ff == S_UPDATE) && out_free;
      cmd.execute = (state_ff == S_EXEC);
      req_tready  = (state_ff == S_IDLE) || cmd.update;
      cmd.accept  = req_tvalid && req_tready;

      state_in = state_ff;
      case (state_ff)
         S_IDLE: begin
            if (cmd.accept) state_in = S_EXEC;
         end
         S_EXEC: begin
            state_in = S_UPDATE;
         end
         S_UPDATE: begin
            if (cmd.update) state_in = cmd.accept ? S_EXEC : S_IDLE;
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase

      rsp_valid_in = rsp_valid_ff;
      if (cmd.update) rsp_valid_in = 1'b1;
      else if (rsp_tready) rsp_valid_in = 1'b0;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;

endmodule

// ===== sv/llh_dp.sv =====
// Datapath: offset register, stamp ring, pointers, histogram and result register.
module llh_dp
   import llh_pkg::*;
#(
   parameter int QUEUE_DEPTH = 4096
)(
   input  logic              clock,
   input  logic              reset,
   input  llh_cmd_type       cmd,
   input  logic              csr_we,
   input  logic [TS_W-1:0]   csr_data,
   input  logic [CMD_W-1:0]  in_command,
   input  logic [TS_W-1:0]   in_timestamp,
   input  logic              in_is_leader,
   input  logic [BIN_W-1:0]  in_bin_index,
   output status_type        out_status,
   output logic [TS_W-1:0]   out_latency,
   output logic [BIN_W-1:0]  out_bin,
   output logic [CNT_W-1:0]  out_bin_count,
   output logic [CNT_W-1:0]  out_overflow_total
);

   localparam int SLOT_W = $clog2(QUEUE_DEPTH);
   localparam int PTR_W  = SLOT_W + 1;

   logic [TS_W-1:0]  ring_mem [QUEUE_DEPTH];
   logic [TS_W-1:0]  stamp_ff;

   logic [TS_W-1:0]  offset_ff, offset_in;
   logic [CMD_W-1:0] cmd_ff, cmd_in;
   logic [TS_W-1:0]  ts_ff, ts_in;
   logic             leader_ff, leader_in;
   logic [BIN_W-1:0] bidx_ff, bidx_in;
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] ovf_ff, ovf_in;
   status_type       status_ff, status_in;
   logic [TS_W-1:0]  lat_ff, lat_in;
   logic [BIN_W-1:0] sel_ff, sel_in;
   logic [CNT_W-1:0] hist_ff [NUM_BINS];
   logic [CNT_W-1:0] hist_in [NUM_BINS];

   status_type       o_status_ff, o_status_in;
   logic [TS_W-1:0]  o_lat_ff, o_lat_in;
   logic [BIN_W-1:0] o_bin_ff, o_bin_in;
   logic [CNT_W-1:0] o_count_ff, o_count_in;
   logic [CNT_W-1:0] o_ovf_ff, o_ovf_in;

   logic [PTR_W-1:0] used;
   logic             ring_we;
   logic [TS_W-1:0]  ring_wdata;
   logic [BIN_W-1:0] upd_bin;
   logic [CNT_W-1:0] upd_count;

   always_comb begin
      offset_in = csr_we ? csr_data : offset_ff;

      cmd_in    = cmd_ff;
      ts_in     = ts_ff;
      leader_in = leader_ff;
      bidx_in   = bidx_ff;
      if (cmd.accept) begin
         cmd_in    = in_command;
         ts_in     = in_timestamp;
         leader_in = in_is_leader;
         bidx_in   = in_bin_index;
      end

      // Execute: pointer bookkeeping, ring write, drop count, latency subtract, bin select.
      used       = wr_ptr_ff - rd_ptr_ff;
      ring_wdata = ts_ff + offset_ff;
      ring_we    = 1'b0;
      wr_ptr_in  = wr_ptr_ff;
      rd_ptr_in  = rd_ptr_ff;
      ovf_in     = ovf_ff;
      status_in  = status_ff;
      lat_in     = lat_ff;
      sel_in     = sel_ff;
      if (cmd.execute) begin
         lat_in = '0;
         sel_in = '0;
         if (cmd_ff == CMD_ENQUEUE) begin
            if (used[PTR_W-1]) begin
               ovf_in    = ovf_ff + 1'b1;
               status_in = ST_DROPPED;
            end else begin
               ring_we   = 1'b1;
               wr_ptr_in = wr_ptr_ff + 1'b1;
               status_in = ST_ENQUEUED;
            end
         end else if (cmd_ff == CMD_SAMPLE) begin
            if (!leader_ff) begin
               status_in = ST_NOT_LEADER;
            end else if (used == '0) begin
               status_in = ST_EMPTY;
            end else begin
               rd_ptr_in = rd_ptr_ff + 1'b1;
               if (stamp_ff == '0) begin
                  status_in = ST_ZERO_STAMP;
               end else begin
                  status_in = ST_SAMPLED;
                  lat_in    = (ts_ff > stamp_ff) ? ts_ff - stamp_ff : '0;
               end
            end
         end else begin
            status_in = ST_BIN_READ;
            sel_in    = (bidx_ff > BIN_W'(NUM_BINS - 1)) ? BIN_W'(NUM_BINS - 1) : bidx_ff;
         end
      end

      // Update: bin the latency, read-modify-write the histogram, load result.
      upd_bin = (status_ff == ST_SAMPLED) ? decade_bin(lat_ff) : sel_ff;
      upd_count = hist_ff[upd_bin] + ((status_ff == ST_SAMPLED) ? CNT_W'(1) : CNT_W'(0));
      for (int i = 0; i < NUM_BINS; i++) hist_in[i] = hist_ff[i];
      o_status_in = o_status_ff;
      o_lat_in    = o_lat_ff;
      o_bin_in    = o_bin_ff;
      o_count_in  = o_count_ff;
      o_ovf_in    = o_ovf_ff;
      if (cmd.update) begin
         if (status_ff == ST_SAMPLED) hist_in[upd_bin] = upd_count;
         o_status_in = status_ff;
         o_lat_in    = lat_ff;
         o_ovf_in    = ovf_ff;
         if (status_ff == ST_SAMPLED || status_ff == ST_BIN_READ) begin
            o_bin_in   = upd_bin;
            o_count_in = upd_count;
         end else begin
            o_bin_in   = '0;
            o_count_in = '0;
         end
      end
   end

   // Ring memory: one write port, one registered read port.
   always_ff @(posedge clock) begin
      if (ring_we) ring_mem[wr_ptr_ff[SLOT_W-1:0]] <= ring_wdata;
      if (cmd.accept) stamp_ff <= ring_mem[rd_ptr_ff[SLOT_W-1:0]];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         offset_ff <= '0;
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         ovf_ff    <= '0;
         for (int i = 0; i < NUM_BINS; i++) hist_ff[i] <= '0;
      end else begin
         offset_ff <= offset_in;
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         ovf_ff    <= ovf_in;
         for (int i = 0; i < NUM_BINS; i++) hist_ff[i] <= hist_in[i];
      end
   end

   always_ff @(posedge clock) begin
      cmd_ff      <= cmd_in;
      ts_ff       <= ts_in;
      leader_ff   <= leader_in;
      bidx_ff     <= bidx_in;
      status_ff   <= status_in;
      lat_ff      <= lat_in;
      sel_ff      <= sel_in;
      o_status_ff <= o_status_in;
      o_lat_ff    <= o_lat_in;
      o_bin_ff    <= o_bin_in;
      o_count_ff  <= o_count_in;
      o_ovf_ff    <= o_ovf_in;
   end

   assign out_status         = o_status_ff;
   assign out_latency        = o_lat_ff;
   assign out_bin            = o_bin_ff;
   assign out_bin_count      = o_count_ff;
   assign out_overflow_total = o_ovf_ff;

endmodule

// ===== sv/launch_latency_histogram.sv =====
// Top level of the launch latency histogram: stream ports, controller and datapath.
// Each item passes through the ring read at accept, execute and update, then its result is registered.
// The next item is accepted in the update cycle, once the result register is free to
//   load; each item needs the registered ring read followed by the histogram read-modify-write.
// Reset (synchronous, active high) clears pointers, overflow count, histogram,
//   clock offset and result valid at once; the stamp ring is not cleared.
module launch_latency_histogram
   import llh_pkg::*;
#(
   parameter int QUEUE_DEPTH = 4096
)(
   input  logic         clock,
   input  logic         reset,
   // Request stream
   input  logic         req_tvalid,
   output logic         req_tready,
   input  logic [71:0]  req_tdata,  // timestamp[63:0], is_leader[64], bin_index[68:65], zero
   input  logic [1:0]   req_tuser,  // command[1:0]
   // Response stream
   output logic         rsp_tvalid,
   input  logic         rsp_tready,
   output logic [199:0] rsp_tdata,  // latency[63:0], bin[67:64], bin_count[131:68],
                                    // overflow_total[195:132], zero
   output logic [2:0]   rsp_tuser,  // status[2:0]
   // Clock offset register write
   input  logic         csr_valid,
   output logic         csr_ready,
   input  logic [63:0]  csr_data
);

   llh_cmd_type      cmd;
   status_type       out_status;
   logic [TS_W-1:0]  out_latency;
   logic [BIN_W-1:0] out_bin;
   logic [CNT_W-1:0] out_bin_count;
   logic [CNT_W-1:0] out_overflow_total;

   // The offset register takes a write in any cycle.
   assign csr_ready = 1'b1;

   llh_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .cmd        (cmd)
   );

   llh_dp #(
      .QUEUE_DEPTH (QUEUE_DEPTH)
   ) u_dp (
      .clock              (clock),
      .reset              (reset),
      .cmd                (cmd),
      .csr_we             (csr_valid && csr_ready),
      .csr_data           (csr_data),
      .in_command         (req_tuser),
      .in_timestamp       (req_tdata[63:0]),
      .in_is_leader       (req_tdata[64]),
      .in_bin_index       (req_tdata[68:65]),
      .out_status         (out_status),
      .out_latency        (out_latency),
      .out_bin            (out_bin),
      .out_bin_count      (out_bin_count),
      .out_overflow_total (out_overflow_total)
   );

   // Pack the result item; unused top bits stay zero.
   assign rsp_tdata = {4'b0000, out_overflow_total, out_bin_count, out_bin, out_latency};
   assign rsp_tuser = out_status;

   // An accepted item always moves to execute in the next cycle.
   a_accept_exec: assert property (@(posedge clock) disable iff (reset)
      (req_tvalid && req_tready) |=> cmd.execute)
      else $error("accepted item did not enter execute");

   // No item is taken while one is executing.
   a_no_accept_exec: assert property (@(posedge clock) disable iff (reset)
      cmd.execute |-> !req_tready)
      else $error("item accepted during execute");

   // A result load always shows a valid result next cycle.
   a_update_valid: assert property (@(posedge clock) disable iff (reset)
      cmd.update |=> rsp_tvalid)
      else $error("result not presented after update");

   // Reset leaves no stale result.
   a_reset_clear: assert property (@(posedge clock)
      reset |=> !rsp_tvalid)
      else $error("result valid right after reset");

endmodule

// ===== test/tb_top.sv =====
`timescale 1ns / 1ps
// Self-checking testbench of launch_latency_histogram: directed table, random traffic, ring fill.
module tb_top;
   import llh_pkg::*;

   localparam int DEPTH          = 4096;
   localparam int PTR_W          = $clog2(DEPTH) + 1;
   localparam int WATCHDOG_LIMIT = 4000;
   localparam int DIR_N          = 26;
   localparam int PHASE_ITEMS    = 160;

   // The package names only enqueue and sample; both remaining codes read a bin.
   localparam logic [CMD_W-1:0] CMD_READ     = 2'd2;
   localparam logic [CMD_W-1:0] CMD_READ_ALT = 2'd3;

   // Upper limit (exclusive) of each decade bin; the last bin takes the rest.
   localparam logic [63:0] DECADE_TOP [NUM_BINS-1] = '{
      64'd100, 64'd1000, 64'd10000, 64'd100000, 64'd1000000,
      64'd10000000, 64'd100000000, 64'd1000000000, 64'd10000000000
   };

   // Offsets of the random phases: both signed extremes, minus one, a small negative.
   localparam logic [63:0] PHASE_OFFSET [4] = '{
      64'h7FFF_FFFF_FFFF_FFFF, 64'h8000_0000_0000_0000,
      64'hFFFF_FFFF_FFFF_FFFF, 64'hFFFF_FFFF_FFFF_F000
   };

   typedef struct packed {
      status_type  status;
      logic [63:0] latency;
      logic [3:0]  bin;
      logic [63:0] count;
      logic [63:0] overflow;
   } latency_rsp_type;

   // One row of the directed table; want is used only where typed is set.
   typedef struct packed {
      logic [1:0]      cmd;
      logic [63:0]     ts;
      logic            leader;
      logic [3:0]      bin_index;
      logic            typed;
      latency_rsp_type want;
   } dir_row_type;

   logic         clock      = 1'b0;
   logic         reset      = 1'b1;
   logic         req_tvalid = 1'b0;
   logic         req_tready;
   logic [71:0]  req_tdata  = '0;  // timestamp[63:0], is_leader[64], bin_index[68:65], zero
   logic [1:0]   req_tuser  = '0;  // command[1:0]
   logic         rsp_tvalid;
   logic         rsp_tready = 1'b0;
   logic [199:0] rsp_tdata;        // latency[63:0], bin[67:64], bin_count[131:68],
                                   // overflow_total[195:132], zero
   logic [2:0]   rsp_tuser;        // status[2:0]
   logic         csr_valid  = 1'b0;
   logic         csr_ready;
   logic [63:0]  csr_data   = '0;

   // Shadow state of the block, advanced on every accepted item.
   logic [63:0]      offset_q   = '0;
   logic [PTR_W-1:0] wr_ptr     = '0;
   logic [PTR_W-1:0] rd_ptr     = '0;
   logic [63:0]      drop_total = '0;
   logic [63:0]      stamp_mem [DEPTH];
   logic [63:0]      hist [NUM_BINS] = '{default: '0};

   latency_rsp_type awaited_rsp [$];   // results still owed by the block, oldest first
   dir_row_type     dir_tab [DIR_N];

   bit              quiet = 1'b0;      // when set, both sides run without gaps
   int              n_items, n_checked, n_errors, n_writes;
   int              seen_status [7] = '{default: 0};
   int              stall_left, rsp_draw, idle_run;
   latency_rsp_type got_want;
   bit              got_ok;

   launch_latency_histogram #(.QUEUE_DEPTH(DEPTH)) uut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_data   (csr_data)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   function automatic logic [63:0] rand64();
      return {$urandom, $urandom};
   endfunction

   // Advance the shadow state by one item and return the result it must produce.
   task automatic predict_step(input logic [1:0] cmd, input logic [63:0] ts,
                               input logic leader, input logic [3:0] bidx,
                               output latency_rsp_type r);
      logic [PTR_W-1:0] used;
      logic [63:0]      stamp;
      logic [3:0]       b;
      used      = wr_ptr - rd_ptr;
      r.status  = ST_BIN_READ;
      r.latency = '0;
      r.bin     = '0;
      r.count   = '0;
      if (cmd == CMD_ENQUEUE) begin
         if (used >= PTR_W'(DEPTH)) begin
            // Ring full: count the drop, leave the write pointer alone.
            drop_total++;
            r.status = ST_DROPPED;
         end else begin
            stamp_mem[wr_ptr[PTR_W-2:0]] = ts + offset_q;
            wr_ptr++;
            r.status = ST_ENQUEUED;
         end
      end else if (cmd == CMD_SAMPLE) begin
         if (!leader) begin
            r.status = ST_NOT_LEADER;
         end else if (used == 0) begin
            r.status = ST_EMPTY;
         end else begin
            stamp = stamp_mem[rd_ptr[PTR_W-2:0]];
            rd_ptr++;
            if (stamp == 0) begin
               r.status = ST_ZERO_STAMP;
            end else begin
               // Clamp a negative latency to zero, then find its decade.
               r.latency = (ts > stamp) ? ts - stamp : '0;
               b = 4'(NUM_BINS - 1);
               for (int i = 0; i < NUM_BINS - 1; i++) begin
                  if (b == 4'(NUM_BINS - 1) && r.latency < DECADE_TOP[i]) b = 4'(i);
               end
               hist[b]++;
               r.bin    = b;
               r.count  = hist[b];
               r.status = ST_SAMPLED;
            end
         end
      end else begin
         b       = (bidx > 4'(NUM_BINS - 1)) ? 4'(NUM_BINS - 1) : bidx;
         r.bin   = b;
         r.count = hist[b];
      end
      r.overflow = drop_total;
   endtask

   // Sample time aimed at a chosen decade relative to the stamp at the head of the ring.
   function automatic logic [63:0] sample_time();
      logic [63:0] head, lo, span, lat;
      int          d;
      if (wr_ptr == rd_ptr) return rand64();
      head = stamp_mem[rd_ptr[PTR_W-2:0]];
      d    = $urandom_range(0, 11);
      if (d == 10) return head - 64'($urandom_range(1, 5000));  // sample before launch
      if (d == 11) return rand64();
      lo   = (d == 0) ? 64'd0 : DECADE_TOP[d-1];
      span = (d == 9) ? 64'd1_000_000_000_000 : DECADE_TOP[d] - lo;
      case ($urandom_range(0, 7))
         0:       lat = lo;
         1:       lat = lo + span - 64'd1;
         default: lat = lo + rand64() % span;
      endcase
      return head + lat;
   endfunction

   // Drive one item, hold it until taken, then record what it must produce.
   task automatic send_item(input logic [1:0] cmd, input logic [63:0] ts,
                            input logic leader, input logic [3:0] bidx,
                            input logic typed, input latency_rsp_type want);
      int              gap;
      latency_rsp_type got;
      gap = quiet ? 0 : $urandom_range(0, 8);
      if (gap != 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= cmd;
      req_tdata  <= {3'b000, bidx, leader, ts};
      do @(posedge clock); while (!req_tready);
      predict_step(cmd, ts, leader, bidx, got);
      awaited_rsp.push_back(typed ? want : got);
      n_items++;
      if ($urandom_range(0, 31) == 0) quiet = !quiet;
   endtask

   // Hold off the sender until every owed result has come back.
   task automatic drain_results();
      req_tvalid <= 1'b0;
      while (awaited_rsp.size() != 0) @(posedge clock);
   endtask

   task automatic settle();
      drain_results();
      repeat (8) @(posedge clock);
   endtask

   task automatic write_offset(input logic [63:0] v);
      csr_valid <= 1'b1;
      csr_data  <= v;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
      offset_q = v;
      n_writes++;
   endtask

   // Mostly enqueue/sample pairs with aimed latencies; the rest is reads and noise.
   task automatic random_item();
      int          r;
      logic [63:0] ts;
      r = $urandom_range(0, 99);
      if (r < 38) begin
         ts = rand64();
         case ($urandom_range(0, 15))
            0:       ts = -offset_q;  // calibrated stamp lands on zero
            1:       ts = '0;
            default: ;
         endcase
         send_item(CMD_ENQUEUE, ts, 1'($urandom), 4'($urandom), 1'b0, '0);
      end else if (r < 76) begin
         send_item(CMD_SAMPLE, sample_time(), 1'b1, 4'($urandom), 1'b0, '0);
      end else if (r < 84) begin
         send_item(CMD_SAMPLE, rand64(), 1'b0, 4'($urandom), 1'b0, '0);
      end else if (r < 96) begin
         send_item(CMD_READ, rand64(), 1'($urandom), 4'($urandom_range(0, 15)), 1'b0, '0);
      end else begin
         send_item(CMD_READ_ALT, rand64(), 1'($urandom), 4'($urandom), 1'b0, '0);
      end
      if ($urandom_range(0, 99) == 0) drain_results();
   endtask

   // Push the ring past full so several enqueues drop, then pop some and read all bins.
   task automatic fill_ring();
      logic [PTR_W-1:0] used;
      int               n;
      used = wr_ptr - rd_ptr;
      n    = DEPTH - int'(used) + 4;
      repeat (n) send_item(CMD_ENQUEUE, rand64(), 1'($urandom), 4'($urandom), 1'b0, '0);
      repeat (24) send_item(CMD_SAMPLE, sample_time(), 1'b1, 4'($urandom), 1'b0, '0);
      for (int b = 0; b < NUM_BINS; b++) begin
         send_item(CMD_READ, rand64(), 1'b0, 4'(b), 1'b0, '0);
      end
   endtask

   function automatic bit same_field(input string name, input logic [63:0] exp_v,
                                     input logic [63:0] act_v);
      if (act_v !== exp_v) begin
         $display("%0t: %s mismatch: expected %0h, got %0h", $time, name, exp_v, act_v);
         return 1'b0;
      end
      return 1'b1;
   endfunction

   // Result side: random stalls on tready, and each taken item compared with the
   // oldest owed result.
   always @(posedge clock) begin
      if (reset) begin
         rsp_tready <= 1'b0;
         stall_left <= 0;
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            if (awaited_rsp.size() == 0) begin
               $display("%0t: result with no item owed: status %0d", $time, rsp_tuser);
               n_errors++;
            end else begin
               got_want = awaited_rsp.pop_front();
               got_ok   = same_field("status", 64'(got_want.status), 64'(rsp_tuser))
                        & same_field("latency", got_want.latency, rsp_tdata[63:0])
                        & same_field("bin", 64'(got_want.bin), 64'(rsp_tdata[67:64]))
                        & same_field("bin_count", got_want.count, rsp_tdata[131:68])
                        & same_field("overflow_total", got_want.overflow,
                                     rsp_tdata[195:132]);
               if (!got_ok) n_errors++;
               n_checked++;
               if (rsp_tuser <= 3'd6) seen_status[rsp_tuser]++;
            end
            rsp_draw = quiet ? 0 : $urandom_range(0, 8);
            rsp_tready <= (rsp_draw == 0);
            stall_left <= rsp_draw;
         end else if (stall_left != 0) begin
            stall_left <= stall_left - 1;
            rsp_tready <= (stall_left == 1);
         end else begin
            rsp_tready <= 1'b1;
         end
      end
   end

   // Watchdog: end the run when no channel moves an item for too long.
   initial begin
      idle_run = 0;
      while (idle_run < WATCHDOG_LIMIT) begin
         @(posedge clock);
         if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)
             || (csr_valid && csr_ready)) begin
            idle_run = 0;
         end else begin
            idle_run++;
         end
      end
      $display("%0t: no item moved for %0d cycles, %0d results owed",
               $time, WATCHDOG_LIMIT, awaited_rsp.size());
      $display("Test completed with failures");
      $finish;
   end

   initial begin
      // Typed rows follow straight from the reset state; the rest go to the predictor.
      dir_tab = '{
         '{CMD_READ,     64'd0,   1'b0, 4'd0,  1'b1, '{ST_BIN_READ, 64'd0, 4'd0, 64'd0, 64'd0}},
         '{CMD_READ,     64'd0,   1'b1, 4'd9,  1'b1, '{ST_BIN_READ, 64'd0, 4'd9, 64'd0, 64'd0}},
         '{CMD_READ,     '1,      1'b0, 4'd15, 1'b1, '{ST_BIN_READ, 64'd0, 4'd9, 64'd0, 64'd0}},
         '{CMD_READ_ALT, 64'd0,   1'b0, 4'd5,  1'b1, '{ST_BIN_READ, 64'd0, 4'd5, 64'd0, 64'd0}},
         '{CMD_SAMPLE,   64'd77,  1'b1, 4'd0,  1'b1, '{ST_EMPTY, 64'd0, 4'd0, 64'd0, 64'd0}},
         '{CMD_SAMPLE,   64'd77,  1'b0, 4'd0,  1'b1, '{ST_NOT_LEADER, 64'd0, 4'd0, 64'd0, 64'd0}},
         '{CMD_ENQUEUE,  64'd0,   1'b0, 4'd0,  1'b1, '{ST_ENQUEUED, 64'd0, 4'd0, 64'd0, 64'd0}},
         '{CMD_SAMPLE,   64'd123, 1'b1, 4'd0,  1'b1, '{ST_ZERO_STAMP, 64'd0, 4'd0, 64'd0, 64'd0}},
         '{CMD_ENQUEUE,  64'd1000, 1'b1, 4'd15, 1'b1, '{ST_ENQUEUED, 64'd0, 4'd0, 64'd0, 64'd0}},
         '{CMD_SAMPLE,   64'd1050, 1'b1, 4'd0, 1'b1, '{ST_SAMPLED, 64'd50, 4'd0, 64'd1, 64'd0}},
         '{CMD_ENQUEUE,  '1,      1'b0, 4'd0,  1'b0, '0},
         '{CMD_SAMPLE,   64'd0,   1'b1, 4'd0,  1'b0, '0},  // launch after entry: clamps
         '{CMD_ENQUEUE,  64'd500, 1'b0, 4'd0,  1'b0, '0},
         '{CMD_SAMPLE,   64'd10000000500, 1'b1, 4'd0, 1'b0, '0},  // exactly 1e10
         '{CMD_ENQUEUE,  64'd100, 1'b0, 4'd0,  1'b0, '0},
         '{CMD_SAMPLE,   64'd199, 1'b1, 4'd0,  1'b0, '0},  // just under the first limit
         '{CMD_ENQUEUE,  64'd100, 1'b0, 4'd0,  1'b0, '0},
         '{CMD_SAMPLE,   64'd200, 1'b1, 4'd0,  1'b0, '0},  // on the first limit
         '{CMD_ENQUEUE,  64'd1,   1'b0, 4'd0,  1'b0, '0},
         '{CMD_SAMPLE,   64'd5,   1'b0, 4'd0,  1'b1, '{ST_NOT_LEADER, 64'd0, 4'd0, 64'd0, 64'd0}},
         '{CMD_SAMPLE,   64'd10000000000, 1'b1, 4'd0, 1'b0, '0},  // just under 1e10
         '{CMD_ENQUEUE,  64'd7,   1'b0, 4'd0,  1'b0, '0},
         '{CMD_SAMPLE,   '1,      1'b1, 4'd0,  1'b0, '0},
         '{CMD_READ,     64'd0,   1'b0, 4'd1,  1'b0, '0},
         '{CMD_READ,     64'd0,   1'b0, 4'd9,  1'b0, '0},
         '{CMD_READ,     64'd0,   1'b0, 4'd8,  1'b0, '0}
      };

      repeat (2) @(posedge clock);
      reset <= 1'b0;

      // Directed table with the offset written back to its reset value.
      write_offset(64'd0);
      foreach (dir_tab[i]) begin
         send_item(dir_tab[i].cmd, dir_tab[i].ts, dir_tab[i].leader, dir_tab[i].bin_index,
                   dir_tab[i].typed, dir_tab[i].want);
      end
      settle();

      // Random phases, each under its own offset; the last one takes a random offset.
      for (int p = 0; p < 5; p++) begin
         write_offset(p < 4 ? PHASE_OFFSET[p] : rand64());
         repeat (PHASE_ITEMS) random_item();
         settle();
      end

      write_offset(rand64());
      fill_ring();
      settle();

      $display("Ran %0d items under %0d offset writes, %0d results checked, %0d enqueues dropped.",
               n_items, n_writes, n_checked, drop_total);
      $display("By status: enq %0d drop %0d sampled %0d empty %0d zero %0d other %0d read %0d",
               seen_status[ST_ENQUEUED], seen_status[ST_DROPPED], seen_status[ST_SAMPLED],
               seen_status[ST_EMPTY], seen_status[ST_ZERO_STAMP], seen_status[ST_NOT_LEADER],
               seen_status[ST_BIN_READ]);
      if (n_errors == 0) begin
         $display("Test completed successfully");
      end else begin
         $display("Test completed with failures");
      end
      $finish;
   end

endmodule
